@@ src/i2c_master_status_sequencer_defines.svh @@
`ifndef I2C_MASTER_STATUS_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_STATUS_SEQUENCER_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define IMS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define IMS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/ims_pkg.sv @@
`default_nettype none

package ims_pkg;

   localparam int BUF_DEPTH_DEFAULT = 32;
   localparam int COUNT_W = 6;
   localparam int WIDE_W = 9;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

   localparam logic [7:0] STAT_START     = 8'h08;
   localparam logic [7:0] STAT_SLAW_ACK  = 8'h18;
   localparam logic [7:0] STAT_SLAW_NACK = 8'h20;
   localparam logic [7:0] STAT_DATA_ACK  = 8'h28;
   localparam logic [7:0] STAT_DATA_NACK = 8'h30;
   localparam logic [7:0] STAT_ARB_LOST  = 8'h38;
   localparam logic [7:0] STAT_SLAR_ACK  = 8'h40;
   localparam logic [7:0] STAT_SLAR_NACK = 8'h48;
   localparam logic [7:0] STAT_RX_ACK    = 8'h50;
   localparam logic [7:0] STAT_RX_NACK   = 8'h58;

   typedef enum logic [1:0] {
      MODE_WRITE,
      MODE_READ,
      MODE_LOAD,
      MODE_STATUS
   } mode_type;

   typedef enum logic [1:0] {
      CTL_NONE,
      CTL_SET,
      CTL_CLR
   } ctl_type;

   typedef enum logic [2:0] {
      OUT_RUN,
      OUT_DONE,
      OUT_ANACK,
      OUT_ARB,
      OUT_BUSY,
      OUT_TRAP
   } outcome_type;

   typedef struct packed {
      mode_type    mode;
      logic [6:0]  address;
      logic [5:0]  length;
      logic [4:0]  byte_index;
      logic [7:0]  byte_value;
      logic [7:0]  status_code;
      logic [7:0]  bus_data;
   } req_type;

   typedef struct packed {
      ctl_type     start_ctl;
      ctl_type     stop_ctl;
      ctl_type     ack_ctl;
      logic        clear_irq;
      logic        load_valid;
      logic [7:0]  data_load;
      logic        rx_valid;
      logic [7:0]  rx_byte;
      logic        busy_res;
      logic [5:0]  transferred_count;
      outcome_type outcome;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic trapped;
   } stat_type;

endpackage

`default_nettype wire

@@ src/ims_stream_if.sv @@
`default_nettype none

interface ims_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ src/i2c_master_status_sequencer.sv @@
// On accept a request is captured with its buffer read; the execute state then
// updates state and commits the response register, stalling while that register
// holds a response not yet taken. No request is accepted until the commit.
// A full response register lets the next request be accepted while it waits.
// Reset (synchronous, active high) clears busy, trap, count, length, address,
// the nack option and handshake state; the data buffer is not cleared.
`default_nettype none

module i2c_master_status_sequencer
   import ims_pkg::*;
#(
   parameter int BUF_DEPTH = BUF_DEPTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    csr_write_en,
   input  wire logic    csr_write_data,
   ims_stream_if.sink   req_if,
   ims_stream_if.source rsp_if
);

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;
   logic     rsp_valid;
   rsp_type  rsp_data;

   ims_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   ims_datapath #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_data       (req_if.payload),
      .rsp_data       (rsp_data),
      .cmd            (cmd),
      .stat           (stat)
   );

   assign req_if.ready   = req_ready;
   assign rsp_if.valid   = rsp_valid;
   assign rsp_if.payload = rsp_data;

endmodule

`default_nettype wire

@@ src/ims_datapath.sv @@
`default_nettype none

module ims_datapath
   import ims_pkg::*;
#(
   parameter int BUF_DEPTH = BUF_DEPTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    csr_write_en,
   input  wire logic    csr_write_data,
   input  wire req_type req_data,
   output rsp_type      rsp_data,
   input  wire cmd_type cmd,
   output stat_type     stat
);

   localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam logic [WIDE_W-1:0] DEPTH_LIM = WIDE_W'(BUF_DEPTH);

   logic [7:0] buf_mem [BUF_DEPTH];

   logic               ignore_ff;
   logic               busy_ff;
   logic               busy_in;
   logic               trapped_ff;
   logic               trapped_in;
   logic [7:0]         addr_byte_ff;
   logic [7:0]         addr_byte_in;
   logic [COUNT_W-1:0] len_ff;
   logic [COUNT_W-1:0] len_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   req_type            item_ff;
   logic [7:0]         rd_data_ff;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   logic [COUNT_W-1:0] count_inc;
   logic [COUNT_W-1:0] rd_sel;
   logic [WIDE_W-1:0]  rd_wide;
   logic [AW-1:0]      rd_addr;
   logic [WIDE_W-1:0]  len_wide;
   logic [WIDE_W-1:0]  len_sat;
   logic [WIDE_W-1:0]  count_wide;
   logic [WIDE_W-1:0]  idx_wide;
   logic [7:0]         status_eff;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [7:0]         mem_wdata;

   assign count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + 6'd1;

   // data ACK (or data NACK with the nack option set) transmits the slot after the count step
   always_comb begin
      rd_sel = count_ff;
      if (req_data.mode == MODE_STATUS &&
          (req_data.status_code == STAT_DATA_ACK ||
           (req_data.status_code == STAT_DATA_NACK && ignore_ff))) begin
         rd_sel = count_inc;
      end
   end

   assign rd_wide    = {(WIDE_W-COUNT_W)'(0), rd_sel};
   assign rd_addr    = rd_wide[AW-1:0];
   assign len_wide   = {(WIDE_W-COUNT_W)'(0), item_ff.length};
   assign len_sat    = (len_wide > DEPTH_LIM) ? DEPTH_LIM : len_wide;
   assign count_wide = {(WIDE_W-COUNT_W)'(0), count_ff};
   assign idx_wide   = {(WIDE_W-5)'(0), item_ff.byte_index};
   assign status_eff = (item_ff.status_code == STAT_DATA_NACK && ignore_ff) ?
                       STAT_DATA_ACK : item_ff.status_code;

   always_comb begin
      busy_in      = busy_ff;
      trapped_in   = trapped_ff;
      addr_byte_in = addr_byte_ff;
      len_in       = len_ff;
      count_in     = count_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx_wide[AW-1:0];
      mem_wdata    = item_ff.byte_value;
      rsp_in       = '0;
      rsp_in.start_ctl = CTL_NONE;
      rsp_in.stop_ctl  = CTL_NONE;
      rsp_in.ack_ctl   = CTL_NONE;
      rsp_in.outcome   = OUT_RUN;
      if (trapped_ff) begin
         rsp_in.outcome = OUT_TRAP;
      end else begin
         case (item_ff.mode)
            MODE_WRITE, MODE_READ: begin
               if (busy_ff) begin
                  rsp_in.outcome = OUT_BUSY;
               end else begin
                  busy_in          = 1'b1;
                  addr_byte_in     = {item_ff.address, item_ff.mode[0]};
                  len_in           = len_sat[COUNT_W-1:0];
                  count_in         = '0;
                  rsp_in.start_ctl = CTL_SET;
               end
            end
            MODE_LOAD: begin
               mem_we = (idx_wide < DEPTH_LIM);
            end
            MODE_STATUS: begin
               rsp_in.clear_irq = 1'b1;
               rsp_in.start_ctl = CTL_CLR;
               case (status_eff)
                  STAT_START: begin
                     rsp_in.load_valid = 1'b1;
                     rsp_in.data_load  = addr_byte_ff;
                  end
                  STAT_SLAW_ACK: begin
                     if (count_ff < len_ff) begin
                        rsp_in.load_valid = 1'b1;
                        rsp_in.data_load  = rd_data_ff;
                        rsp_in.stop_ctl   = CTL_CLR;
                     end else begin
                        rsp_in.stop_ctl = CTL_SET;
                        busy_in         = 1'b0;
                        rsp_in.outcome  = OUT_DONE;
                     end
                  end
                  STAT_SLAW_NACK, STAT_SLAR_NACK: begin
                     rsp_in.stop_ctl = CTL_SET;
                     count_in        = '0;
                     busy_in         = 1'b0;
                     rsp_in.outcome  = OUT_ANACK;
                  end
                  STAT_DATA_ACK: begin
                     count_in = count_inc;
                     if (count_inc < len_ff) begin
                        rsp_in.load_valid = 1'b1;
                        rsp_in.data_load  = rd_data_ff;
                        rsp_in.stop_ctl   = CTL_CLR;
                     end else begin
                        rsp_in.stop_ctl = CTL_SET;
                        busy_in         = 1'b0;
                        rsp_in.outcome  = OUT_DONE;
                     end
                  end
                  STAT_DATA_NACK, STAT_RX_NACK: begin
                     rsp_in.stop_ctl = CTL_SET;
                     busy_in         = 1'b0;
                     rsp_in.outcome  = OUT_DONE;
                  end
                  STAT_ARB_LOST: begin
                     rsp_in.stop_ctl = CTL_CLR;
                     busy_in         = 1'b0;
                     rsp_in.outcome  = OUT_ARB;
                  end
                  STAT_SLAR_ACK: begin
                     rsp_in.stop_ctl = CTL_CLR;
                     rsp_in.ack_ctl  = (count_ff < len_ff) ? CTL_SET : CTL_CLR;
                  end
                  STAT_RX_ACK: begin
                     if (count_wide < DEPTH_LIM) begin
                        mem_we          = 1'b1;
                        rsp_in.rx_valid = 1'b1;
                        rsp_in.rx_byte  = item_ff.bus_data;
                     end
                     mem_waddr       = count_wide[AW-1:0];
                     mem_wdata       = item_ff.bus_data;
                     count_in        = count_inc;
                     rsp_in.stop_ctl = CTL_CLR;
                     rsp_in.ack_ctl  = (count_inc < len_ff) ? CTL_SET : CTL_CLR;
                  end
                  default: begin
                     rsp_in.clear_irq = 1'b0;
                     rsp_in.start_ctl = CTL_NONE;
                     trapped_in       = 1'b1;
                     rsp_in.outcome   = OUT_TRAP;
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
      rsp_in.busy_res          = busy_in;
      rsp_in.transferred_count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ignore_ff    <= 1'b0;
         busy_ff      <= 1'b0;
         trapped_ff   <= 1'b0;
         addr_byte_ff <= '0;
         len_ff       <= '0;
         count_ff     <= '0;
      end else begin
         if (csr_write_en) begin
            ignore_ff <= csr_write_data;
         end
         if (cmd.commit) begin
            busy_ff      <= busy_in;
            trapped_ff   <= trapped_in;
            addr_byte_ff <= addr_byte_in;
            len_ff       <= len_in;
            count_ff     <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff    <= req_data;
         rd_data_ff <= buf_mem[rd_addr];
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && mem_we) begin
         buf_mem[mem_waddr] <= mem_wdata;
      end
   end

   assign rsp_data     = rsp_ff;
   assign stat.busy    = busy_ff;
   assign stat.trapped = trapped_ff;

endmodule

`default_nettype wire

@@ src/ims_ctrl.sv @@
`default_nettype none

`include "i2c_master_status_sequencer_defines.svh"

module ims_ctrl
   import ims_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output cmd_type       cmd,
   input  wire stat_type stat
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   assign req_ready   = (state_ff == ST_IDLE);
   assign cmd.capture = req_valid && req_ready;
   assign cmd.commit  = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (cmd.commit) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `IMS_ASSERT_NEXT(a_accept_to_exec, req_valid && req_ready, state_ff == ST_EXEC, "accepted request not executed")
   `IMS_ASSERT_IMPLIES(a_rsp_from_exec, $rose(rsp_valid_ff), $past(state_ff) == ST_EXEC, "response without execution")
   `IMS_ASSERT_NEXT(a_trap_sticky, stat.trapped, stat.trapped, "trap flag released")
   `IMS_ASSERT_IMPLIES(a_busy_on_commit, $rose(stat.busy), $past(cmd.commit), "busy rose without commit")

endmodule

`default_nettype wire
